/* rtl/tcf_pkg.sv */
// Shared types, constants and tables for the tilt complementary filter.
`default_nettype none
package tcf_pkg;
  localparam int CordicSteps = 16;
  localparam int AtanLen = 24;
  localparam int Steps = (CordicSteps > AtanLen) ? AtanLen : CordicSteps;
  localparam int AngleWidth = 16;
  localparam int StepW = $clog2(AtanLen + 1);
  localparam int unsigned RateDivisor = 67072;
  // ceil(2^32 / 131): exact quotient for any dividend below 2^28
  localparam logic [24:0] RateRecip = 25'd32786010;

  typedef enum logic [1:0] {
    REG_GYRO_X_OFFSET = 2'd0,
    REG_GYRO_Y_OFFSET = 2'd1,
    REG_BLEND_WEIGHT  = 2'd2,
    REG_SAMPLE_PERIOD = 2'd3
  } reg_idx_t;

  // Word handed from the front part to the back part.
  typedef struct packed {
    logic signed [16:0] num_roll;
    logic [16:0]        den_roll;
    logic signed [16:0] num_pitch;
    logic [16:0]        den_pitch;
    logic signed [16:0] delta_roll;
    logic signed [16:0] delta_pitch;
  } job_t;

  typedef struct packed {
    logic signed [15:0] gx_off;
    logic signed [15:0] gy_off;
    logic [15:0]        weight;
    logic [15:0]        period;
  } cfg_t;

  function automatic logic [21:0] atan_q16(input logic [StepW-1:0] i);
    logic [21:0] r;
    begin
      case (i)
        5'd0: r = 22'd2949120;  5'd1: r = 22'd1740967;  5'd2: r = 22'd919879;
        5'd3: r = 22'd466945;   5'd4: r = 22'd234379;   5'd5: r = 22'd117304;
        5'd6: r = 22'd58666;    5'd7: r = 22'd29335;    5'd8: r = 22'd14668;
        5'd9: r = 22'd7334;     5'd10: r = 22'd3667;    5'd11: r = 22'd1833;
        5'd12: r = 22'd917;     5'd13: r = 22'd458;     5'd14: r = 22'd229;
        5'd15: r = 22'd115;     5'd16: r = 22'd57;      5'd17: r = 22'd29;
        5'd18: r = 22'd14;      5'd19: r = 22'd7;       5'd20: r = 22'd4;
        5'd21: r = 22'd2;       5'd22: r = 22'd1;
        default: r = 22'd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

/* rtl/tcf_if.sv */
// Valid/ready channel interfaces for samples, results and register writes.
`default_nettype none
interface tcf_in_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x_raw;
  logic signed [15:0] rate_y_raw;
  modport source (output valid, accel_x, accel_y, accel_z, rate_x_raw, rate_y_raw,
                  input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, rate_x_raw, rate_y_raw,
                output ready);
endinterface

interface tcf_out_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [15:0] roll_out;
  logic signed [15:0] pitch_out;
  modport source (output valid, roll_out, pitch_out, input ready);
  modport sink (input valid, roll_out, pitch_out, output ready);
endinterface

interface tcf_cfg_if (input logic clk);
  logic valid;
  logic ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/tcf_front.sv */
// Front part: squares, integer square roots and gyro increments for one sample.
`default_nettype none
module tcf_front (
  input  logic          clk,
  input  logic          rst,
  tcf_in_if.sink        in_ch,
  input  tcf_pkg::cfg_t cfg,
  output logic          job_valid,
  input  logic          job_ready,
  output tcf_pkg::job_t job
);
  import tcf_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_SQ   = 5'b00010,
    F_MUL  = 5'b00100,
    F_ROOT = 5'b01000,
    F_DONE = 5'b10000
  } fstate_t;

  fstate_t state;
  logic signed [15:0] ax, ay, az;
  logic signed [16:0] rx, ry;
  logic [31:0] sq_x, sq_y, sq_z;
  logic [33:0] rad_r, rad_p;
  logic [16:0] res_r, res_p;
  logic [33:0] rem_r, rem_p;
  logic [4:0]  cnt;
  logic signed [33:0] prod_x, prod_y;
  logic [32:0] mag_x, mag_y;
  logic        neg_x, neg_y;
  logic [16:0] q_x, q_y;
  logic [33:0] try_r, try_p;
  logic [33:0] rem_r_next, rem_p_next;
  logic [16:0] res_r_next, res_p_next;
  logic [48:0] qp_x, qp_y;

  assign in_ch.ready = (state == F_IDLE);
  assign job_valid = (state == F_DONE);

  // Restoring square root: two radicand bits per cycle.
  always_comb begin
    rem_r_next = {rem_r[31:0], rad_r[33:32]};
    rem_p_next = {rem_p[31:0], rad_p[33:32]};
    try_r = {15'd0, res_r, 2'b01};
    try_p = {15'd0, res_p, 2'b01};
    res_r_next = {res_r[15:0], 1'b0};
    res_p_next = {res_p[15:0], 1'b0};
    if (rem_r_next >= try_r) begin
      rem_r_next = rem_r_next - try_r;
      res_r_next[0] = 1'b1;
    end
    if (rem_p_next >= try_p) begin
      rem_p_next = rem_p_next - try_p;
      res_p_next[0] = 1'b1;
    end
  end

  // Divide by the rate divisor: drop the factor of 512, then multiply by 1/131.
  assign qp_x = 49'(mag_x[32:9]) * 49'(RateRecip);
  assign qp_y = 49'(mag_y[32:9]) * 49'(RateRecip);

  // Sequence one sample through the front part.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_ch.valid) begin
            ax <= in_ch.accel_x;
            ay <= in_ch.accel_y;
            az <= in_ch.accel_z;
            rx <= 17'(in_ch.rate_x_raw) - 17'(cfg.gx_off);
            ry <= 17'(in_ch.rate_y_raw) - 17'(cfg.gy_off);
            state <= F_SQ;
          end
        end
        F_SQ: begin
          sq_x <= 32'(ax * ax);
          sq_y <= 32'(ay * ay);
          sq_z <= 32'(az * az);
          prod_x <= rx * $signed({1'b0, cfg.period});
          prod_y <= ry * $signed({1'b0, cfg.period});
          state <= F_MUL;
        end
        F_MUL: begin
          rad_r <= {2'b00, sq_x} + {2'b00, sq_z};
          rad_p <= {2'b00, sq_y} + {2'b00, sq_z};
          rem_r <= '0;
          rem_p <= '0;
          res_r <= '0;
          res_p <= '0;
          neg_x <= prod_x[33];
          neg_y <= prod_y[33];
          // Pre-add half the divisor for round to nearest, ties away from zero.
          mag_x <= 33'(prod_x[33] ? -prod_x : prod_x) + 33'(RateDivisor / 2);
          mag_y <= 33'(prod_y[33] ? -prod_y : prod_y) + 33'(RateDivisor / 2);
          cnt <= '0;
          state <= F_ROOT;
        end
        F_ROOT: begin
          rem_r <= rem_r_next;
          rem_p <= rem_p_next;
          res_r <= res_r_next;
          res_p <= res_p_next;
          rad_r <= {rad_r[31:0], 2'b00};
          rad_p <= {rad_p[31:0], 2'b00};
          q_x <= qp_x[48:32];
          q_y <= qp_y[48:32];
          cnt <= cnt + 5'd1;
          if (cnt == 5'd16) begin
            state <= F_DONE;
          end
        end
        F_DONE: begin
          if (job_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Pack the word for the back part.
  always_comb begin
    job.num_roll    = 17'(ay);
    job.den_roll    = res_r;
    job.num_pitch   = -17'(ax);
    job.den_pitch   = res_p;
    job.delta_roll  = neg_x ? -$signed(q_x) : $signed(q_x);
    job.delta_pitch = neg_y ? -$signed(q_y) : $signed(q_y);
  end
endmodule
`default_nettype wire

/* rtl/tcf_queue.sv */
// Two-entry queue of job words between the front and back parts.
`default_nettype none
module tcf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  tcf_pkg::job_t wr_job,
  output logic          rd_valid,
  input  logic          rd_ready,
  output tcf_pkg::job_t rd_job
);
  import tcf_pkg::*;

  job_t slot [2];
  logic wptr, rptr;
  logic [1:0] count;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job = slot[rptr];

  // Store and drop words.
  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      slot[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= '0;
    end else begin
      if (wr_valid && wr_ready) begin
        wptr <= ~wptr;
      end
      if (rd_valid && rd_ready) begin
        rptr <= ~rptr;
      end
      count <= count + 2'((wr_valid && wr_ready) ? 1 : 0)
                     - 2'((rd_valid && rd_ready) ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

/* rtl/tcf_back.sv */
// Back part: shared CORDIC arctangent, blend and saturation of both angles.
`default_nettype none
module tcf_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  tcf_pkg::job_t job,
  input  tcf_pkg::cfg_t cfg,
  tcf_out_if.source     out_ch
);
  import tcf_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_ROT   = 6'b000010,
    B_MUL   = 6'b000100,
    B_SUM   = 6'b001000,
    B_NEXT  = 6'b010000,
    B_OUT   = 6'b100000
  } bstate_t;

  localparam logic signed [AngleWidth-1:0] AngMax = {1'b0, {(AngleWidth-1){1'b1}}};
  localparam logic signed [AngleWidth-1:0] AngMin = {1'b1, {(AngleWidth-1){1'b0}}};

  bstate_t state;
  logic    axis;  // 0 roll, 1 pitch
  job_t    cur;
  logic signed [AngleWidth-1:0] roll_angle, pitch_angle;
  logic signed [32:0] cx, cy;
  logic signed [23:0] cz;
  logic [StepW-1:0] step;
  logic signed [15:0] acc_ang;
  logic signed [AngleWidth+1:0] gsum;
  logic signed [AngleWidth+17:0] pw, pa;
  logic signed [AngleWidth+19:0] tot;
  logic signed [AngleWidth+3:0] bl;
  logic signed [AngleWidth-1:0] bl_sat;
  logic signed [32:0] xs, ys;
  logic signed [23:0] zr;
  logic signed [AngleWidth-1:0] old_ang;
  logic signed [16:0] dlt;
  logic zero_vec;

  assign job_ready = (state == B_IDLE);
  assign out_ch.valid = (state == B_OUT);
  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign zr = cz + 24'sd256;
  assign old_ang = axis ? pitch_angle : roll_angle;
  assign dlt = axis ? cur.delta_pitch : cur.delta_roll;
  assign acc_ang = zero_vec ? 16'sd0 : 16'(zr >>> 9);
  assign gsum = (AngleWidth+2)'(old_ang) + (AngleWidth+2)'(dlt);
  assign tot = (AngleWidth+20)'(pw) + (AngleWidth+20)'(pa) + (AngleWidth+20)'(32768);
  assign bl = (AngleWidth+4)'(tot >>> 16);
  assign bl_sat = (bl > (AngleWidth+4)'(AngMax)) ? AngMax :
                  (bl < (AngleWidth+4)'(AngMin)) ? AngMin : AngleWidth'(bl);

  // Present the kept angles, saturated to the port width.
  always_comb begin
    if (AngleWidth > 16) begin
      out_ch.roll_out = (roll_angle > 32767) ? 16'sh7fff :
                        (roll_angle < -32768) ? 16'sh8000 : 16'(roll_angle);
      out_ch.pitch_out = (pitch_angle > 32767) ? 16'sh7fff :
                         (pitch_angle < -32768) ? 16'sh8000 : 16'(pitch_angle);
    end else begin
      out_ch.roll_out = 16'(roll_angle);
      out_ch.pitch_out = 16'(pitch_angle);
    end
  end

  // Run the CORDIC per axis, then blend.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      axis <= 1'b0;
      roll_angle <= '0;
      pitch_angle <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            cur <= job;
            axis <= 1'b0;
            cx <= 33'({job.den_roll, 14'd0});
            cy <= 33'($signed({job.num_roll, 14'd0}));
            zero_vec <= (job.den_roll == 0) && (job.num_roll == 0);
            cz <= '0;
            step <= '0;
            state <= B_ROT;
          end
        end
        B_ROT: begin
          if (cy < 0) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - $signed({2'b00, atan_q16(step)});
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + $signed({2'b00, atan_q16(step)});
          end
          step <= step + 1'b1;
          if (step == StepW'(Steps - 1)) begin
            state <= B_MUL;
          end
        end
        B_MUL: begin
          pw <= (AngleWidth+18)'(gsum * $signed({1'b0, cfg.weight}));
          pa <= (AngleWidth+18)'(acc_ang * $signed(18'd65536 - 18'(cfg.weight)));
          state <= B_SUM;
        end
        B_SUM: begin
          if (axis) begin
            pitch_angle <= bl_sat;
            state <= B_OUT;
          end else begin
            roll_angle <= bl_sat;
            state <= B_NEXT;
          end
        end
        B_NEXT: begin
          axis <= 1'b1;
          cx <= 33'({cur.den_pitch, 14'd0});
          cy <= 33'($signed({cur.num_pitch, 14'd0}));
          zero_vec <= (cur.den_pitch == 0) && (cur.num_pitch == 0);
          cz <= '0;
          step <= '0;
          state <= B_ROT;
        end
        B_OUT: begin
          if (out_ch.ready) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/tilt_complementary_filter.sv */
// An accepted input word passes through the front part (squares, 17 square root
// steps, reciprocal divide) and then the back part (16 CORDIC steps, blend and
// save, once per axis) before its result word appears.
// Front and back overlap through a queue, so the front can take a new word
// while the back still works on earlier ones; the shared CORDIC sets the rate and output stalls hold it.
// Synchronous reset restores the register defaults and zeroes both angles.
`default_nettype none
module tilt_complementary_filter (
  input  logic   clk,
  input  logic   rst,
  tcf_in_if.sink    in_ch,
  tcf_out_if.source out_ch,
  tcf_cfg_if.sink   cfg_ch
);
  import tcf_pkg::*;

  cfg_t cfg;
  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  assign cfg_ch.ready = 1'b1;

  // Take register writes; unknown indexes cannot occur in two bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gx_off <= 16'sd21;
      cfg.gy_off <= -16'sd2;
      cfg.weight <= 16'd19661;
      cfg.period <= 16'd6554;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_GYRO_X_OFFSET: cfg.gx_off <= cfg_ch.data;
        REG_GYRO_Y_OFFSET: cfg.gy_off <= cfg_ch.data;
        REG_BLEND_WEIGHT:  cfg.weight <= cfg_ch.data;
        REG_SAMPLE_PERIOD: cfg.period <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  tcf_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg(cfg),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  tcf_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job)
  );

  tcf_back u_back (
    .clk(clk), .rst(rst), .job_valid(b_valid), .job_ready(b_ready),
    .job(b_job), .cfg(cfg), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

/* verif/tb_tilt_complementary_filter.sv */
// Testbench for the tilt complementary filter: random and directed samples checked against a predictor.
`default_nettype none
module tb_tilt_complementary_filter;
  import tcf_pkg::*;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
  } tilt_t;

  typedef enum logic [1:0] {
    GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH
  } gap_mode_t;

  localparam int LIMIT = 2000000;

  logic clk;
  logic rst;
  tcf_in_if  in_ch (clk);
  tcf_out_if out_ch (clk);
  tcf_cfg_if cfg_ch (clk);

  tilt_complementary_filter DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  // Predictor state and configuration
  longint gx_off, gy_off, weight, period, roll_q, pitch_q;
  sample_t pending_samples[$];
  tilt_t   tilt_expected[$];
  gap_mode_t gap_mode;
  int   hold_off;
  bit   send_paused;
  bit   failed;
  int   cycle_count;

  const longint AtanTab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
    29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  function automatic longint fshift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint tilt_deg(longint n, longint m);
    longint x, y, z, xs, ys;
    z = 0;
    if (n == 0 && m == 0) return 0;
    x = m * 16384;
    y = n * 16384;
    for (int i = 0; i < Steps; i++) begin
      xs = fshift(x, i);
      ys = fshift(y, i);
      if (y < 0) begin
        x = x - ys; y = y + xs; z = z - AtanTab[i];
      end else begin
        x = x + ys; y = y - xs; z = z + AtanTab[i];
      end
    end
    return fshift(z + 256, 9);
  endfunction

  function automatic longint rate_step(longint rate);
    longint p, q;
    p = rate * period;
    q = ((p < 0 ? -p : p) + RateDivisor / 2) / RateDivisor;
    return p < 0 ? -q : q;
  endfunction

  function automatic longint mix(longint g, longint a);
    longint v;
    v = fshift(weight * g + (65536 - weight) * a + 32768, 16);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic tilt_t predict_tilt(sample_t s);
    longint ax, ay, az, mr, mp;
    tilt_t t;
    ax = s.ax; ay = s.ay; az = s.az;
    mr = int_sqrt(ax * ax + az * az);
    mp = int_sqrt(ay * ay + az * az);
    roll_q  = mix(roll_q + rate_step(longint'(s.rx) - gx_off), tilt_deg(ay, mr));
    pitch_q = mix(pitch_q + rate_step(longint'(s.ry) - gy_off), tilt_deg(-ax, mp));
    t.roll = roll_q[15:0];
    t.pitch = pitch_q[15:0];
    return t;
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drive samples from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        tilt_expected.push_back(predict_tilt(pending_samples.pop_front()));
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (pending_samples.size() > 0 && !send_paused &&
            !((gap_mode == GAP_SEND || gap_mode == GAP_BOTH) &&
              $urandom_range(99) < (gap_mode == GAP_BOTH ? 11 : 56))) begin
          in_ch.valid      <= 1;
          in_ch.accel_x    <= pending_samples[0].ax;
          in_ch.accel_y    <= pending_samples[0].ay;
          in_ch.accel_z    <= pending_samples[0].az;
          in_ch.rate_x_raw <= pending_samples[0].rx;
          in_ch.rate_y_raw <= pending_samples[0].ry;
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // Hold off the result side as the phase asks
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= !((gap_mode == GAP_RECV || gap_mode == GAP_BOTH) &&
                        $urandom_range(99) < (gap_mode == GAP_BOTH ? 11 : 56));
    end
  end

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    tilt_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (tilt_expected.size() == 0) begin
        $error("result with nothing expected: roll %0d pitch %0d",
               out_ch.roll_out, out_ch.pitch_out);
        failed = 1;
      end else begin
        e = tilt_expected.pop_front();
        if (e.roll !== out_ch.roll_out) begin
          $error("roll_out: expected %0d, got %0d", e.roll, out_ch.roll_out);
          failed = 1;
        end
        if (e.pitch !== out_ch.pitch_out) begin
          $error("pitch_out: expected %0d, got %0d", e.pitch, out_ch.pitch_out);
          failed = 1;
        end
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    case (idx)
      REG_GYRO_X_OFFSET: gx_off = longint'($signed(val));
      REG_GYRO_Y_OFFSET: gy_off = longint'($signed(val));
      REG_BLEND_WEIGHT:  weight = val;
      REG_SAMPLE_PERIOD: period = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && !in_ch.valid && tilt_expected.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(40)) - 16'd20;
      default: return 16'($urandom);
    endcase
  endfunction

  // Realistic samples most of the time: accelerations within +/-16384, small rates
  function automatic sample_t random_sample();
    sample_t s;
    if ($urandom_range(9) < 7) begin
      s.ax = 16'($signed($urandom_range(32768)) - 16384);
      s.ay = 16'($signed($urandom_range(32768)) - 16384);
      s.az = 16'($signed($urandom_range(32768)) - 16384);
      s.rx = 16'($signed($urandom_range(8000)) - 4000);
      s.ry = 16'($signed($urandom_range(8000)) - 4000);
    end else begin
      s = {pick16(), pick16(), pick16(), pick16(), pick16()};
    end
    return s;
  endfunction

  task automatic run_phase(gap_mode_t m, int n);
    gap_mode = m;
    for (int i = 0; i < n; i++) pending_samples.push_back(random_sample());
    drain();
  endtask

  initial begin
    sample_t s;
    rst = 1;
    gap_mode = GAP_NONE;
    hold_off = 0;
    send_paused = 0;
    failed = 0;
    cycle_count = 0;
    in_ch.valid = 0;
    in_ch.accel_x = 0; in_ch.accel_y = 0; in_ch.accel_z = 0;
    in_ch.rate_x_raw = 0; in_ch.rate_y_raw = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = REG_GYRO_X_OFFSET; cfg_ch.data = 0;
    gx_off = 21; gy_off = -2; weight = 19661; period = 6554;
    roll_q = 0; pitch_q = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: zero vector, extremes, steady rotation into saturation
    pending_samples.push_back('0);
    pending_samples.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
    pending_samples.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    pending_samples.push_back({16'h0000, 16'h4000, 16'h0000, 16'h0015, 16'hFFFE});
    pending_samples.push_back({16'hC000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    pending_samples.push_back({16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000});
    pending_samples.push_back({16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000});
    drain();
    write_reg(REG_BLEND_WEIGHT, 16'hFFFF);
    write_reg(REG_SAMPLE_PERIOD, 16'hFFFF);
    write_reg(REG_GYRO_X_OFFSET, 16'h8000);
    write_reg(REG_GYRO_Y_OFFSET, 16'h7FFF);
    for (int i = 0; i < 10; i++)
      pending_samples.push_back({16'h0000, 16'h0000, 16'h4000, 16'h7FFF, 16'h8000});
    drain();
    write_reg(REG_BLEND_WEIGHT, 16'h0000);
    write_reg(REG_SAMPLE_PERIOD, 16'h0000);
    pending_samples.push_back({16'h1234, 16'hEDCB, 16'h0100, 16'h7FFF, 16'h8000});
    pending_samples.push_back('0);
    drain();

    // Random phases under several settings
    write_reg(REG_GYRO_X_OFFSET, 16'd21);
    write_reg(REG_GYRO_Y_OFFSET, 16'hFFFE);
    write_reg(REG_BLEND_WEIGHT, 16'd19661);
    write_reg(REG_SAMPLE_PERIOD, 16'd6554);
    run_phase(GAP_NONE, 400);
    write_reg(REG_BLEND_WEIGHT, 16'd64880);
    write_reg(REG_SAMPLE_PERIOD, 16'($urandom));
    write_reg(REG_GYRO_X_OFFSET, 16'($urandom));
    run_phase(GAP_SEND, 400);
    write_reg(REG_BLEND_WEIGHT, 16'($urandom));
    write_reg(REG_GYRO_Y_OFFSET, 16'($urandom));
    write_reg(REG_SAMPLE_PERIOD, 16'hFFFF);
    run_phase(GAP_RECV, 400);

    // Long receiver hold-off while samples keep coming
    gap_mode = GAP_NONE;
    hold_off = 3000;
    for (int i = 0; i < 60; i++) pending_samples.push_back(random_sample());
    // Pause the sender until everything has come back
    wait (pending_samples.size() < 30);
    send_paused = 1;
    wait (tilt_expected.size() == 0 && !in_ch.valid && hold_off == 0);
    send_paused = 0;
    drain();

    write_reg(REG_BLEND_WEIGHT, 16'd1);
    write_reg(REG_SAMPLE_PERIOD, 16'd655);
    run_phase(GAP_BOTH, 400);

    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
